// ===== sv/mm4_pkg.sv =====
// shared types and constants for the 4x4 fixed-point matrix multiplier
// no dependencies

package mm4_pkg;

  localparam int MM_N         = 4;
  localparam int MM_DW        = 32;
  localparam int MM_IDX_W     = 2;
  localparam int MM_PROD_W    = 2 * MM_DW;
  localparam int MM_ACC_W     = MM_PROD_W + 2;
  localparam int MM_FRAC_BITS = 16;

  // operand token that walks down the chain of cells
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic [MM_IDX_W-1:0] k;
    logic [MM_DW-1:0]    a;
  } mm4_tok_t;

  // finished element of one product row from a cell
  typedef struct packed {
    logic             done;
    logic             sat;
    logic [MM_DW-1:0] value;
  } mm4_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN
  } mm4_state_t;

endpackage

// ===== sv/matrix_multiply_4x4.sv =====
// top level of the 4x4 fixed-point matrix multiplier: left store, sequencer,
// chain of four column cells and the result register; depends on mm4_pkg, mm4_cell
//
// Each request loads one row of A and the same row of B. A row 3 request then
// raises busy: the sequencer streams the sixteen elements of A, one per cycle,
// down a chain of four cells (one per output column, each with its own
// multiplier), and the four result rows come out on out_valid pulses. busy stays
// high after a row 3 request until the last cell finishes the fourth result row,
// through the sixteen multiplies per cell and the chain and pipeline depth.
// Results cannot be held off: out_valid is high for exactly one cycle per result.

module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int FRAC_BITS = MM_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MM_IDX_W-1:0] in_row_index,
  input  logic [MM_DW-1:0]    in_a_col0,
  input  logic [MM_DW-1:0]    in_a_col1,
  input  logic [MM_DW-1:0]    in_a_col2,
  input  logic [MM_DW-1:0]    in_a_col3,
  input  logic [MM_DW-1:0]    in_b_col0,
  input  logic [MM_DW-1:0]    in_b_col1,
  input  logic [MM_DW-1:0]    in_b_col2,
  input  logic [MM_DW-1:0]    in_b_col3,
  output logic                out_valid,
  output logic [MM_IDX_W-1:0] out_row,
  output logic [MM_DW-1:0]    out_c_col0,
  output logic [MM_DW-1:0]    out_c_col1,
  output logic [MM_DW-1:0]    out_c_col2,
  output logic [MM_DW-1:0]    out_c_col3,
  output logic                out_saturated,
  output logic                out_last_row
);

  localparam int CNT_W = 2 * MM_IDX_W;
  localparam logic [MM_IDX_W-1:0] LAST_IDX = MM_IDX_W'(MM_N - 1);
  localparam logic [CNT_W-1:0]    LAST_CNT = CNT_W'(MM_N * MM_N - 1);

  logic                accept;
  logic [MM_DW-1:0]    a_r [MM_N][MM_N];
  logic [MM_DW-1:0]    b_in [MM_N];
  mm4_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    feed_cnt_r, feed_cnt_nxt;
  logic [MM_IDX_W-1:0] emit_cnt_r, emit_cnt_nxt;
  mm4_tok_t            tok [MM_N+1];
  mm4_res_t            res [MM_N];
  logic                row_done;

  logic                out_valid_r;
  logic [MM_IDX_W-1:0] out_row_r;
  logic [MM_DW-1:0]    out_c_r [MM_N];
  logic                out_sat_r;
  logic                out_last_r;

  assign accept   = start && !busy;
  assign row_done = res[MM_N-1].done;

  assign b_in[0] = in_b_col0;
  assign b_in[1] = in_b_col1;
  assign b_in[2] = in_b_col2;
  assign b_in[3] = in_b_col3;

  // left store, written one row per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MM_N; i++) begin
        for (int k = 0; k < MM_N; k++) begin
          a_r[i][k] <= '0;
        end
      end
    end else if (accept) begin
      a_r[in_row_index][0] <= in_a_col0;
      a_r[in_row_index][1] <= in_a_col1;
      a_r[in_row_index][2] <= in_a_col2;
      a_r[in_row_index][3] <= in_a_col3;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    feed_cnt_nxt = feed_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    busy         = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy         = 1'b0;
        feed_cnt_nxt = '0;
        emit_cnt_nxt = '0;
        // busy is low here, so start alone marks an accepted request
        if (start && in_row_index == LAST_IDX) begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        feed_cnt_nxt = feed_cnt_r + 1'b1;
        if (feed_cnt_r == LAST_CNT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (row_done && emit_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (row_done) begin
      emit_cnt_nxt = emit_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      feed_cnt_r <= '0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      feed_cnt_r <= feed_cnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  // element a[i][k] enters the chain, i and k taken from the feed count
  always_comb begin
    tok[0].vld   = (state_r == ST_FEED);
    tok[0].k     = feed_cnt_r[MM_IDX_W-1:0];
    tok[0].first = (feed_cnt_r[MM_IDX_W-1:0] == '0);
    tok[0].last  = (feed_cnt_r[MM_IDX_W-1:0] == LAST_IDX);
    tok[0].a     = a_r[feed_cnt_r[CNT_W-1:MM_IDX_W]][feed_cnt_r[MM_IDX_W-1:0]];
  end

  for (genvar j = 0; j < MM_N; j++) begin : g_cell
    mm4_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (accept),
      .wr_row  (in_row_index),
      .wr_data (b_in[j]),
      .tok_in  (tok[j]),
      .tok_out (tok[j+1]),
      .res     (res[j])
    );
  end

  // each cell finishes a row in the cycle after its left neighbour; each result holds until the last is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= row_done;
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      out_row_r  <= emit_cnt_r;
      out_last_r <= (emit_cnt_r == LAST_IDX);
      out_sat_r  <= res[0].sat || res[1].sat || res[2].sat || res[3].sat;
      for (int j = 0; j < MM_N; j++) begin
        out_c_r[j] <= res[j].value;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_c_col0    = out_c_r[0];
  assign out_c_col1    = out_c_r[1];
  assign out_c_col2    = out_c_r[2];
  assign out_c_col3    = out_c_r[3];
  assign out_saturated = out_sat_r;
  assign out_last_row  = out_last_r;

endmodule

// ===== sv/mm4_cell.sv =====
// one column cell: holds column j of the right matrix, multiplies and accumulates
// depends on mm4_pkg

module mm4_cell import mm4_pkg::*; #(
  parameter int FRAC_BITS = MM_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [MM_IDX_W-1:0] wr_row,
  input  logic [MM_DW-1:0]    wr_data,
  input  mm4_tok_t            tok_in,
  output mm4_tok_t            tok_out,
  output mm4_res_t            res
);

  logic [MM_DW-1:0]           b_r [MM_N];
  mm4_tok_t                   tok_r;
  logic signed [MM_PROD_W-1:0] prod_r, prod_nxt;
  logic                       p_vld_r, p_first_r, p_last_r;
  logic signed [MM_ACC_W-1:0] acc_r, acc_nxt, shifted;
  logic                       acc_last_r;
  logic                       ovf;
  mm4_res_t                   res_r, res_nxt;

  assign prod_nxt = $signed(tok_in.a) * $signed(b_r[tok_in.k]);

  always_comb begin
    if (p_first_r) begin
      acc_nxt = {{2{prod_r[MM_PROD_W-1]}}, prod_r};
    end else begin
      acc_nxt = acc_r + {{2{prod_r[MM_PROD_W-1]}}, prod_r};
    end
  end

  // floor shift, then clip to the signed 32-bit range
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    ovf     = !((&shifted[MM_ACC_W-1:MM_DW-1]) || !(|shifted[MM_ACC_W-1:MM_DW-1]));
    res_nxt = res_r;
    res_nxt.done = acc_last_r;
    if (acc_last_r) begin
      res_nxt.sat = ovf;
      if (!ovf) begin
        res_nxt.value = shifted[MM_DW-1:0];
      end else if (acc_r[MM_ACC_W-1]) begin
        res_nxt.value = {1'b1, {(MM_DW-1){1'b0}}};
      end else begin
        res_nxt.value = {1'b0, {(MM_DW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MM_N; i++) begin
        b_r[i] <= '0;
      end
      tok_r      <= '0;
      p_vld_r    <= 1'b0;
      p_first_r  <= 1'b0;
      p_last_r   <= 1'b0;
      acc_last_r <= 1'b0;
      res_r      <= '0;
    end else begin
      if (wr_en) begin
        b_r[wr_row] <= wr_data;
      end
      tok_r      <= tok_in;
      p_vld_r    <= tok_in.vld;
      p_first_r  <= tok_in.vld && tok_in.first;
      p_last_r   <= tok_in.vld && tok_in.last;
      acc_last_r <= p_last_r;
      res_r      <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign tok_out = tok_r;
  assign res     = res_r;

endmodule

// ===== verif/tb_matrix_multiply_4x4.sv =====
// testbench for matrix_multiply_4x4: random row-load requests, products predicted and
// checked row by row against the result strobes
// depends on mm4_pkg and matrix_multiply_4x4

module tb_matrix_multiply_4x4 import mm4_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC           = MM_FRAC_BITS;
  localparam int LAST_IDX       = MM_N - 1;
  localparam int NUM_REQS       = 220;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [MM_ACC_W-1:0] ELEM_MAX = 66'sh7FFFFFFF;
  localparam logic signed [MM_ACC_W-1:0] ELEM_MIN = -66'sh80000000;

  typedef logic [MM_N-1:0][MM_DW-1:0] mat_row_t;

  typedef struct packed {
    logic [MM_IDX_W-1:0] row;
    mat_row_t            a;
    mat_row_t            b;
  } row_load_t;

  typedef struct packed {
    logic [MM_IDX_W-1:0] row;
    mat_row_t            c;
    logic                sat;
    logic                last;
  } product_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MM_IDX_W-1:0] in_row_index = '0;
  logic [MM_DW-1:0] in_a_col0 = '0, in_a_col1 = '0, in_a_col2 = '0, in_a_col3 = '0;
  logic [MM_DW-1:0] in_b_col0 = '0, in_b_col1 = '0, in_b_col2 = '0, in_b_col3 = '0;
  logic out_valid;
  logic [MM_IDX_W-1:0] out_row;
  logic [MM_DW-1:0] out_c_col0, out_c_col1, out_c_col2, out_c_col3;
  logic out_saturated;
  logic out_last_row;

  row_load_t    pending_loads[$];
  product_row_t product_rows[$];
  mat_row_t     left_mat [MM_N];
  mat_row_t     right_mat[MM_N];

  int issued_cnt = 0;
  int taken_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int num_loads = 0;

  matrix_multiply_4x4 #(.FRAC_BITS(FRAC)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_row_index  (in_row_index),
    .in_a_col0     (in_a_col0),
    .in_a_col1     (in_a_col1),
    .in_a_col2     (in_a_col2),
    .in_a_col3     (in_a_col3),
    .in_b_col0     (in_b_col0),
    .in_b_col1     (in_b_col1),
    .in_b_col2     (in_b_col2),
    .in_b_col3     (in_b_col3),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_c_col0    (out_c_col0),
    .out_c_col1    (out_c_col1),
    .out_c_col2    (out_c_col2),
    .out_c_col3    (out_c_col3),
    .out_saturated (out_saturated),
    .out_last_row  (out_last_row)
  );

  always #5 clk = ~clk;

  // exact sum of four products, floor shift, clip to 32 bits
  task automatic compute_product();
    logic signed [MM_ACC_W-1:0]  acc;
    logic signed [MM_ACC_W-1:0]  scaled;
    logic signed [MM_PROD_W-1:0] prod;
    product_row_t                res;
    for (int i = 0; i < MM_N; i++) begin
      res = '0;
      res.row = MM_IDX_W'(i);
      res.last = (i == LAST_IDX);
      for (int j = 0; j < MM_N; j++) begin
        acc = '0;
        for (int k = 0; k < MM_N; k++) begin
          prod = $signed(left_mat[i][k]) * $signed(right_mat[k][j]);
          acc = acc + prod;
        end
        scaled = acc >>> FRAC;
        if (scaled > ELEM_MAX) begin
          res.c[j] = 32'h7FFFFFFF;
          res.sat = 1'b1;
        end else if (scaled < ELEM_MIN) begin
          res.c[j] = 32'h80000000;
          res.sat = 1'b1;
        end else begin
          res.c[j] = scaled[MM_DW-1:0];
        end
      end
      product_rows.push_back(res);
    end
  endtask

  // 0: within +-2.0, 1: within +-128.0, 2: any pattern, 3: corner values
  function automatic logic [MM_DW-1:0] rand_elem(int kind);
    logic [MM_DW-1:0] v;
    if ($urandom_range(0, 7) == 0) kind = $urandom_range(0, 3);
    case (kind)
      0: v = $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
      1: v = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          3: v = 32'hFFFFFFFF;
          4: v = 32'h00010000;
          default: v = 32'h00000001;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_load(int row, mat_row_t a, mat_row_t b);
    row_load_t r;
    r.row = MM_IDX_W'(row);
    r.a = a;
    r.b = b;
    pending_loads.push_back(r);
    num_loads++;
  endtask

  task automatic push_rand_load(int row, int kind);
    mat_row_t a, b;
    for (int j = 0; j < MM_N; j++) begin
      a[j] = rand_elem(kind);
      b[j] = rand_elem(kind);
    end
    push_load(row, a, b);
  endtask

  // driver: one request on the bus at a time, sent in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (taken_cnt != issued_cnt) begin
      // request still waiting for busy to drop
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_loads.size() != 0) begin
      row_load_t r;
      r = pending_loads.pop_front();
      start        <= 1'b1;
      in_row_index <= r.row;
      in_a_col0    <= r.a[0];
      in_a_col1    <= r.a[1];
      in_a_col2    <= r.a[2];
      in_a_col3    <= r.a[3];
      in_b_col0    <= r.b[0];
      in_b_col1    <= r.b[1];
      in_b_col2    <= r.b[2];
      in_b_col3    <= r.b[3];
      issued_cnt   <= issued_cnt + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check result rows, then update the stores from an accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        product_row_t got, want;
        got.row  = out_row;
        got.c    = {out_c_col3, out_c_col2, out_c_col1, out_c_col0};
        got.sat  = out_saturated;
        got.last = out_last_row;
        if (product_rows.size() == 0) begin
          errors++;
          $display("%0t: unexpected result row, expected none, actual row %0d",
                   $time, got.row);
        end else begin
          want = product_rows.pop_front();
          if (got.row !== want.row) begin
            errors++;
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
          end
          for (int j = 0; j < MM_N; j++) begin
            if (got.c[j] !== want.c[j]) begin
              errors++;
              $display("%0t: row %0d c_col%0d expected %h actual %h",
                       $time, want.row, j, want.c[j], got.c[j]);
            end
          end
          if (got.sat !== want.sat) begin
            errors++;
            $display("%0t: row %0d saturated expected %b actual %b",
                     $time, want.row, want.sat, got.sat);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: row %0d last_row expected %b actual %b",
                     $time, want.row, want.last, got.last);
          end
        end
      end
      if (start && !busy) begin
        taken_cnt <= taken_cnt + 1;
        left_mat[in_row_index]  = {in_a_col3, in_a_col2, in_a_col1, in_a_col0};
        right_mat[in_row_index] = {in_b_col3, in_b_col2, in_b_col1, in_b_col0};
        if (in_row_index == LAST_IDX) compute_product();
      end
    end
  end

  // watchdog: give up after a long stretch with no request or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mat_row_t a, b;
    int kind, n, row;
    for (int i = 0; i < MM_N; i++) begin
      left_mat[i] = '0;
      right_mat[i] = '0;
    end

    // row 3 alone after reset: other rows read as zero
    push_load(3, {32'h00008000, 32'hFFFF0000, 32'h00020000, 32'h00010000},
                 {32'h00030000, 32'hFFFE8000, 32'h00004000, 32'h7FFFFFFF});
    // identity times a small random matrix
    for (int i = 0; i < MM_N; i++) begin
      a = '0;
      a[i] = 32'h00010000;
      for (int j = 0; j < MM_N; j++) b[j] = rand_elem(0);
      push_load(i, a, b);
    end
    // positive clip from max by max, then from min by min, negative clip from max by min
    for (int i = 0; i < MM_N; i++) push_load(i, {MM_N{32'h7FFFFFFF}}, {MM_N{32'h7FFFFFFF}});
    for (int i = 0; i < MM_N; i++) push_load(i, {MM_N{32'h80000000}}, {MM_N{32'h80000000}});
    for (int i = 0; i < MM_N; i++) push_load(i, {MM_N{32'h7FFFFFFF}}, {MM_N{32'h80000000}});
    // floor on negative sums, a rewritten row, then a recompute from the kept stores
    push_load(0, {32'h0, 32'h0, 32'h0, 32'hFFFFFFFF}, {32'h1, 32'h1, 32'h1, 32'h1});
    push_load(1, {MM_N{32'h12345678}}, {MM_N{32'h80000000}});
    push_load(1, '0, '0);
    push_load(2, {32'h0, 32'h0, 32'h00010000, 32'h0}, {32'h0, 32'hFFFFFFFF, 32'h0, 32'h1});
    push_load(3, {32'h00010000, 32'h0, 32'h0, 32'h0}, {32'hFFFF8000, 32'h0, 32'h0, 32'h0});
    push_load(3, {32'h0, 32'h00020000, 32'h0, 32'hFFFFFFFF}, {MM_N{32'hFFFFFFFF}});

    while (num_loads < NUM_REQS) begin
      kind = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        7, 8: begin
          // partial or shuffled set of rows
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) push_rand_load($urandom_range(0, LAST_IDX), kind);
        end
        9: push_rand_load(LAST_IDX, kind);
        default: begin
          for (row = 0; row < MM_N; row++) push_rand_load(row, kind);
        end
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_loads.size() != 0 || taken_cnt != issued_cnt) @(negedge clk);
    while (product_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
